// ===== sv/assert_macros.svh =====
// Assertion helpers used by the walker core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_IMPLIES_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_IMPLIES_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/ptw_pkg.sv =====
package ptw_pkg;

    localparam int unsigned ADDR_W   = 64;
    localparam int unsigned IDX_W    = 9;
    localparam int unsigned OFFS_W   = 12;
    localparam int unsigned WORD_SH  = 3;

    localparam logic [ADDR_W-1:0] FRAME_MASK = 64'hFFFF_FFFF_FFFF_F000;

    // Opcodes of an input word
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_XLATE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FAULT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Walk levels
    localparam logic [1:0] LVL_FIRST = 2'd0;
    localparam logic [1:0] LVL_LAST  = 2'd3;

    typedef enum logic [0:0] {
        S_IDLE,
        S_WAIT
    } t_state;

    // Lookup token handed from cell to cell
    typedef struct packed {
        logic              vld;
        logic              store;
        logic              hit;
        logic              done;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] val;
    } t_token;

    // Byte offset of the table entry selected by one level of the walk
    function automatic logic [ADDR_W-1:0] entry_offset(input logic [ADDR_W-1:0] laddr,
                                                       input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        begin
            case (lvl)
                2'd0:    idx = laddr[47:39];
                2'd1:    idx = laddr[38:30];
                2'd2:    idx = laddr[29:21];
                default: idx = laddr[20:12];
            endcase
            entry_offset = {{(ADDR_W-IDX_W-WORD_SH){1'b0}}, idx, {WORD_SH{1'b0}}};
        end
    endfunction

endpackage

// ===== sv/ptw_cell.sv =====
module ptw_cell
    import ptw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_token i_tok,
    output t_token o_tok
);

    logic              r_valid;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_val;
    t_token            r_tok;
    t_token            n_tok;
    logic              w_match;
    logic              w_write;

    // Compare the passing token against the held entry
    assign w_match = r_valid && i_tok.vld && !i_tok.hit && (r_addr == i_tok.addr);
    // Claim this entry: first empty cell reached by a store that found no copy
    assign w_write = i_tok.vld && i_tok.store && !r_valid && !i_tok.hit && !i_tok.done;

    always_comb begin
        n_tok = i_tok;
        if (w_match) begin
            n_tok.hit = 1'b1;
            if (!i_tok.store) begin
                n_tok.val = r_val;
            end
        end
        if (w_write) begin
            n_tok.done = 1'b1;
        end
    end

    // Hold the entry, fill it once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_write) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_addr <= i_tok.addr;
            r_val  <= i_tok.val;
        end
    end

    // Advance the token to the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== sv/four_level_page_table_walker_core.sv =====
// Four-level page walker over a small associative memory held in a row of
// TABLE_ENTRIES cells. A word is accepted when start is high and busy is low.
// Every lookup travels the whole row, one cell per cycle, and the block stays
// busy while the lookups of a word are in the row: a store (kept, repeated or
// dropped) makes one lookup and a translate makes up to four lookups, fewer
// when a level faults. The result
// appears on o_physical_address/o_status for exactly one cycle with o_strobe
// high, in the first cycle in which busy is low again; the receiver cannot
// stall it, so it must take every word as it comes. Stores and repeated
// stores give no result; a store into a full table gives status 2. Cells fill
// in arrival order and need no clearing pass after reset. Write the root
// register only while idle.
module four_level_page_table_walker_core
    import ptw_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata,
    input  logic              start,
    output logic              busy,
    input  logic              i_opcode,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [ADDR_W-1:0] i_entry_value,
    output logic              o_strobe,
    output logic [ADDR_W-1:0] o_physical_address,
    output logic [1:0]        o_status
);

`include "assert_macros.svh"

    t_state            r_state, n_state;
    logic [1:0]        r_lvl, n_lvl;
    logic              r_op, n_op;
    logic [ADDR_W-1:0] r_laddr, n_laddr;
    t_token            r_tok, n_tok;
    logic [ADDR_W-1:0] r_root;
    logic              r_ostb, n_ostb;
    logic [ADDR_W-1:0] r_opa, n_opa;
    logic [1:0]        r_ostatus, n_ostatus;
    logic [ADDR_W-1:0] w_frame;
    t_token            w_link [0:TABLE_ENTRIES];
    t_token            w_exit;

    // Row of cells; the injected token enters the first one
    assign w_link[0] = r_tok;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ptw_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_link[g]),
            .o_tok   (w_link[g+1])
        );
    end

    assign w_exit  = w_link[TABLE_ENTRIES];
    assign w_frame = w_exit.val & FRAME_MASK;

    // Root table register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_cfg_we) begin
            r_root <= i_cfg_wdata;
        end
    end

    // Sequence stores and walk levels
    always_comb begin
        n_state   = r_state;
        n_lvl     = r_lvl;
        n_op      = r_op;
        n_laddr   = r_laddr;
        n_tok     = r_tok;
        n_tok.vld = 1'b0;
        n_ostb    = 1'b0;
        n_opa     = r_opa;
        n_ostatus = r_ostatus;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op       = i_opcode;
                    n_laddr    = i_address;
                    n_lvl      = LVL_FIRST;
                    n_tok.vld  = 1'b1;
                    n_tok.store = (i_opcode == OP_STORE);
                    n_tok.hit  = 1'b0;
                    n_tok.done = 1'b0;
                    n_tok.val  = i_entry_value;
                    if (i_opcode == OP_STORE) begin
                        n_tok.addr = i_address;
                    end else begin
                        n_tok.addr = r_root + entry_offset(i_address, LVL_FIRST);
                    end
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_exit.vld) begin
                    if (r_op == OP_STORE) begin
                        n_state = S_IDLE;
                        // Drop the word when no copy and no free cell was found
                        if (!w_exit.hit && !w_exit.done) begin
                            n_ostb    = 1'b1;
                            n_opa     = '0;
                            n_ostatus = ST_FULL;
                        end
                    end else if (!w_exit.hit || !w_exit.val[0]) begin
                        n_state   = S_IDLE;
                        n_ostb    = 1'b1;
                        n_opa     = '0;
                        n_ostatus = ST_FAULT;
                    end else if (r_lvl == LVL_LAST) begin
                        n_state   = S_IDLE;
                        n_ostb    = 1'b1;
                        n_opa     = w_frame |
                                    {{(ADDR_W-OFFS_W){1'b0}}, r_laddr[OFFS_W-1:0]};
                        n_ostatus = ST_OK;
                    end else begin
                        // Issue the next level from the fetched table frame
                        n_lvl      = r_lvl + 2'd1;
                        n_tok.vld  = 1'b1;
                        n_tok.store = 1'b0;
                        n_tok.hit  = 1'b0;
                        n_tok.done = 1'b0;
                        n_tok.addr = w_frame + entry_offset(r_laddr, n_lvl);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tok.vld <= 1'b0;
            r_ostb    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tok   <= n_tok;
            r_ostb  <= n_ostb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl     <= n_lvl;
        r_op      <= n_op;
        r_laddr   <= n_laddr;
        r_opa     <= n_opa;
        r_ostatus <= n_ostatus;
    end

    assign busy               = (r_state != S_IDLE);
    assign o_strobe           = r_ostb;
    assign o_physical_address = r_opa;
    assign o_status           = r_ostatus;

    // A token leaves the row only while a lookup is outstanding
    `ASSERT_IMPLIES(a_exit_in_wait, i_clk, i_rst_n, w_exit.vld, r_state == S_WAIT, "token left row while idle")
    // An accepted word injects a token in the next cycle
    `ASSERT_IMPLIES_NEXT(a_accept_injects, i_clk, i_rst_n, i_rst_n && start && !busy, r_tok.vld, "accepted word not injected")
    // A result only follows a lookup leaving the row
    `ASSERT_IMPLIES_NEXT(a_result_source, i_clk, i_rst_n, i_rst_n && !w_exit.vld, !o_strobe, "result without a finished lookup")
    // Faults and dropped stores report a zero address
    `ASSERT_IMPLIES(a_fail_zero, i_clk, i_rst_n, o_strobe && (o_status != ST_OK), o_physical_address == '0, "failed result carries an address")

endmodule
